// ===== design/breath_volume_segmenter_core_defines.svh =====
// Assertion macros for the breath volume segmenter core.
`ifndef BREATH_VOLUME_SEGMENTER_CORE_DEFINES_SVH
`define BREATH_VOLUME_SEGMENTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define BVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define BVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bvs_pkg.sv =====
// Package with field widths, opcodes and register indexes of the breath segmenter.
package bvs_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned FLOW_W   = 16;
  localparam int unsigned VOL_W    = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned PROD_W   = THR_W + PERIOD_W;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_NONE   = 2'd3
  } bvs_op_e;

  typedef enum logic [1:0] {
    REG_INHALE_THR = 2'd0,
    REG_EXHALE_THR = 2'd1,
    REG_PERIOD     = 2'd2,
    REG_UNUSED     = 2'd3
  } bvs_reg_e;

  localparam logic [THR_W-1:0]    INHALE_THR_RST = 15'd100;
  localparam logic [THR_W-1:0]    EXHALE_THR_RST = 15'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 10'd100;

endpackage

// ===== design/bvs_if.sv =====
// Valid/ready channel interfaces for the segmenter command and result streams.
interface bvs_in_if import bvs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic signed [FLOW_W-1:0] flow_sample;

  modport source (output valid, opcode, flow_sample, input ready);
  modport sink   (input valid, opcode, flow_sample, output ready);
endinterface

interface bvs_out_if import bvs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VOL_W-1:0]   current_volume;
  logic [COUNT_W-1:0] breath_tally;
  logic               breath_done;
  logic               inhaling;
  logic               session_active;
  logic               summary_valid;
  logic [VOL_W-1:0]   mean_volume;

  modport source (output valid, current_volume, breath_tally, breath_done, inhaling,
                  session_active, summary_valid, mean_volume, input ready);
  modport sink   (input valid, current_volume, breath_tally, breath_done, inhaling,
                  session_active, summary_valid, mean_volume, output ready);
endinterface

// ===== design/bvs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 10
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/breath_volume_segmenter_core.sv =====
// Top level of the breath volume segmenter: command decode, ring walk and mean divider.
//
//  channel   dir  handshake        payload
//  in_i      in   valid / ready    opcode, flow_sample
//  out_o     out  valid / ready    current_volume, breath_tally, breath_done,
//                                  inhaling, session_active, summary_valid,
//                                  mean_volume
//  apb       in   psel / penable   paddr, pwdata -> prdata (pready tied high)
//
// Samples, starts and unknown opcodes go through accept, execute and emit.
// A stop also walks the ring RAM one entry per cycle through its single read
// port, then a restoring divider produces one quotient bit per cycle, skipped
// when no entry was used, before the emit step.
// Reset is asynchronous, active low; it clears flags, counters, the ring valid
// bits and the register file. The ring RAM itself is never swept.
// A new transaction is taken whenever the core is idle, even while the last
// result still waits in the output register; a full output register stalls
// only the emit step.
`include "breath_volume_segmenter_core_defines.svh"

module breath_volume_segmenter_core import bvs_pkg::*; #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bvs_in_if.sink            in_i,
  bvs_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Ring index, entry count and divider widths all follow the ring depth.
  localparam int unsigned PW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned TW  = VOL_W + CW;
  localparam int unsigned DCW = $clog2(TW + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Register file.
  logic [THR_W-1:0]    inh_thr_q, exh_thr_q;
  logic [PERIOD_W-1:0] period_q;

  // Session state.
  logic               active_q, active_d;
  logic               inhale_q, inhale_d;
  logic [VOL_W-1:0]   vol_q, vol_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [RING_DEPTH-1:0] valid_q, valid_d;

  // Latched transaction and per-result flags.
  logic [OPCODE_W-1:0]      op_q;
  logic signed [FLOW_W-1:0] flow_q;
  logic [PROD_W-1:0]        prod_q;
  logic done_q, done_d;
  logic summ_q, summ_d;
  logic [VOL_W-1:0] mean_q, mean_d;

  // Ring walk and divider.
  logic [CW-1:0]  idx_q, idx_d;
  logic           rd_pend_q, rd_pend_d;
  logic           rd_ok_q, rd_ok_d;
  logic [TW-1:0]  total_q, total_d;
  logic [CW-1:0]  used_q, used_d;
  logic [CW-1:0]  rem_q, rem_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;

  // RAM port signals.
  logic             ram_we;
  logic [PW-1:0]    ram_raddr;
  logic [VOL_W-1:0] ram_rdata;

  // Output register.
  logic               ovalid_q;
  logic               oload;
  logic [VOL_W-1:0]   o_vol_q;
  logic [COUNT_W-1:0] o_count_q;
  logic               o_done_q, o_inhale_q, o_active_q, o_summ_q;
  logic [VOL_W-1:0]   o_mean_q;

  logic in_fire;
  logic cfg_wr;
  logic [1:0] cfg_idx;

  // Sample classification and arithmetic.
  logic                     above_inh;
  logic                     below_exh;
  logic signed [FLOW_W:0]   flow_ext;
  logic signed [FLOW_W:0]   neg_exh;
  logic [VOL_W:0]           vol_sum;
  logic [CW:0]              trial;
  logic                     trial_ge;

  // ---------------------------------------------------------------------------
  // Configuration port: write at the access phase with pready tied high, comb read.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inh_thr_q <= INHALE_THR_RST;
      exh_thr_q <= EXHALE_THR_RST;
      period_q  <= PERIOD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_INHALE_THR: inh_thr_q <= pwdata[THR_W-1:0];
        REG_EXHALE_THR: exh_thr_q <= pwdata[THR_W-1:0];
        REG_PERIOD:     period_q  <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_INHALE_THR: prdata = {{(APB_DW-THR_W){1'b0}}, inh_thr_q};
      REG_EXHALE_THR: prdata = {{(APB_DW-THR_W){1'b0}}, exh_thr_q};
      REG_PERIOD:     prdata = {{(APB_DW-PERIOD_W){1'b0}}, period_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side: latch the transaction and form flow * period right away.
  // The product is only consumed when flow is above a nonnegative threshold,
  // so the magnitude bits below the sign are enough.
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      flow_q <= in_i.flow_sample;
      prod_q <= PROD_W'(in_i.flow_sample[THR_W-1:0]) * PROD_W'(period_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_SAMPLE;
    end else if (in_fire) begin
      op_q <= in_i.opcode;
    end
  end

  assign flow_ext  = {flow_q[FLOW_W-1], flow_q};
  assign neg_exh   = (FLOW_W+1)'(0) - $signed({2'b00, exh_thr_q});
  assign above_inh = flow_q > $signed({1'b0, inh_thr_q});
  assign below_exh = flow_ext < neg_exh;
  assign vol_sum   = {1'b0, vol_q} + (VOL_W+1)'(prod_q);

  assign trial     = {rem_q, total_q[TW-1]};
  assign trial_ge  = trial >= {1'b0, used_q};

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    active_d  = active_q;
    inhale_d  = inhale_q;
    vol_d     = vol_q;
    count_d   = count_q;
    pos_d     = pos_q;
    valid_d   = valid_q;
    done_d    = done_q;
    summ_d    = summ_q;
    mean_d    = mean_q;
    idx_d     = idx_q;
    rd_pend_d = 1'b0;
    rd_ok_d   = 1'b0;
    total_d   = total_q;
    used_d    = used_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    ram_we    = 1'b0;
    ram_raddr = idx_q[PW-1:0];
    oload     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        done_d  = 1'b0;
        summ_d  = 1'b0;
        mean_d  = '0;
        state_d = ST_EMIT;
        case (op_q)
          OP_SAMPLE: begin
            if (active_q) begin
              if (above_inh) begin
                inhale_d = 1'b1;
                vol_d    = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];
              end else if (below_exh && inhale_q) begin
                // Close the breath: store it, advance the ring, count it.
                inhale_d       = 1'b0;
                ram_we         = 1'b1;
                valid_d[pos_q] = 1'b1;
                pos_d          = (pos_q == PW'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
                count_d        = count_q + 1'b1;
                vol_d          = '0;
                done_d         = 1'b1;
              end
            end
          end
          OP_START: begin
            // Dropping the valid bits empties the ring without a RAM write.
            active_d = 1'b1;
            vol_d    = '0;
            count_d  = '0;
            valid_d  = '0;
          end
          OP_STOP: begin
            active_d = 1'b0;
            summ_d   = 1'b1;
            idx_d    = '0;
            total_d  = '0;
            used_d   = '0;
            state_d  = ST_SUM;
          end
          default: ;
        endcase
      end

      ST_SUM: begin
        // Issue one read per cycle; accumulate the entry read last cycle if valid and nonzero.
        if (idx_q != CW'(RING_DEPTH)) begin
          rd_pend_d = 1'b1;
          rd_ok_d   = valid_q[idx_q[PW-1:0]];
          idx_d     = idx_q + 1'b1;
        end
        if (rd_pend_q && rd_ok_q && (ram_rdata != '0)) begin
          total_d = total_q + TW'(ram_rdata);
          used_d  = used_q + 1'b1;
        end
        if (idx_q == CW'(RING_DEPTH) && !rd_pend_q) begin
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        if (used_q == '0) begin
          mean_d  = '0;
          state_d = ST_EMIT;
        end else begin
          // Restoring division, one quotient bit per cycle into total_q.
          rem_d   = trial_ge ? CW'(trial - {1'b0, used_q}) : trial[CW-1:0];
          total_d = {total_q[TW-2:0], trial_ge};
          dcnt_d  = dcnt_q + 1'b1;
          if (dcnt_q == DCW'(TW - 1)) begin
            mean_d  = total_d[VOL_W-1:0];
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (!ovalid_q || out_o.ready) begin
          oload   = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      active_q  <= 1'b0;
      inhale_q  <= 1'b0;
      vol_q     <= '0;
      count_q   <= '0;
      pos_q     <= '0;
      valid_q   <= '0;
      done_q    <= 1'b0;
      summ_q    <= 1'b0;
      mean_q    <= '0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_ok_q   <= 1'b0;
      used_q    <= '0;
      dcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      inhale_q  <= inhale_d;
      vol_q     <= vol_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      valid_q   <= valid_d;
      done_q    <= done_d;
      summ_q    <= summ_d;
      mean_q    <= mean_d;
      idx_q     <= idx_d;
      rd_pend_q <= rd_pend_d;
      rd_ok_q   <= rd_ok_d;
      used_q    <= used_d;
      dcnt_q    <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    rem_q   <= rem_d;
  end

  // ---------------------------------------------------------------------------
  // Breath ring storage.
  // ---------------------------------------------------------------------------
  bvs_ram #(
    .WIDTH (VOL_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (vol_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the result until the sink takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (oload) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oload) begin
      o_vol_q    <= vol_q;
      o_count_q  <= count_q;
      o_done_q   <= done_q;
      o_inhale_q <= inhale_q;
      o_active_q <= active_q;
      o_summ_q   <= summ_q;
      o_mean_q   <= mean_q;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.current_volume = o_vol_q;
  assign out_o.breath_tally   = o_count_q;
  assign out_o.breath_done    = o_done_q;
  assign out_o.inhaling       = o_inhale_q;
  assign out_o.session_active = o_active_q;
  assign out_o.summary_valid  = o_summ_q;
  assign out_o.mean_volume    = o_mean_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `BVS_ASSERT_NOW(a_ring_wr_in_session, ram_we, (state_q == ST_EXEC) && active_q,
                  "ring written outside an active sample step")
  `BVS_ASSERT_NOW(a_pos_in_range, 1'b1, pos_q <= PW'(RING_DEPTH - 1),
                  "ring position beyond ring depth")
  `BVS_ASSERT_NOW(a_used_bounded, state_q == ST_DIV, used_q <= CW'(RING_DEPTH),
                  "more used entries than ring depth")
  `BVS_ASSERT_NOW(a_done_clears, ovalid_q && o_done_q,
                  (o_vol_q == '0) && !o_inhale_q && !o_summ_q,
                  "closed breath left volume or inhale flag set")
  `BVS_ASSERT_NEXT(a_summary_ends_session, oload && summ_q,
                   ovalid_q && o_summ_q && !o_active_q,
                   "summary result with session still active")

endmodule
